// ===== src/arabic_script_run_classifier_defines.svh =====
// Assertion macros for the Arabic script run classifier.
// Used by the top level; needs nothing else.
`ifndef ARABIC_SCRIPT_RUN_CLASSIFIER_DEFINES_SVH
`define ARABIC_SCRIPT_RUN_CLASSIFIER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset.
`define ARSRC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define ARSRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ARSRC_ASSERT(lbl, clk, rst_n, prop, msg)
`define ARSRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/arsrc_pkg.sv =====
// Shared types, constants and code point range checks for the Arabic script
// run classifier. No dependencies.
package arsrc_pkg;

  localparam int unsigned CP_W = 21;
  typedef logic [CP_W-1:0] cp_t;

  // One decoded entry per accepted byte; cp is zero when the byte closes no sequence.
  typedef struct packed {
    cp_t  cp;
    logic last;
  } cp_item_t;

  localparam int unsigned Q_AW    = 2;
  localparam int unsigned Q_DEPTH = 1 << Q_AW;
  typedef logic [Q_AW:0]   q_cnt_t;
  typedef logic [Q_AW-1:0] q_ptr_t;
  localparam q_cnt_t Q_CNT_FULL = q_cnt_t'(Q_DEPTH);

  // Open sequence length, none when no sequence is open.
  localparam logic [2:0] SEQ_NONE = 3'd0;
  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  localparam cp_t ARB_LO   = cp_t'(21'h00600);
  localparam cp_t ARB_HI   = cp_t'(21'h006FF);
  localparam cp_t SUP_LO   = cp_t'(21'h00750);
  localparam cp_t SUP_HI   = cp_t'(21'h0077F);
  localparam cp_t EXTB_LO  = cp_t'(21'h00870);
  localparam cp_t EXTB_HI  = cp_t'(21'h008FF);
  localparam cp_t PFA_LO   = cp_t'(21'h0FB50);
  localparam cp_t PFA_HI   = cp_t'(21'h0FDFF);
  localparam cp_t PFB_LO   = cp_t'(21'h0FE70);
  localparam cp_t PFB_HI   = cp_t'(21'h0FEFF);
  localparam cp_t DIG_LO   = cp_t'(21'h00660);
  localparam cp_t DIG_HI   = cp_t'(21'h00669);
  localparam cp_t SEP_LO   = cp_t'(21'h0066B);
  localparam cp_t SEP_HI   = cp_t'(21'h0066C);
  localparam cp_t EDIG_LO  = cp_t'(21'h006F0);
  localparam cp_t EDIG_HI  = cp_t'(21'h006F9);

  typedef struct packed {
    logic pop;
    logic pop_last;
  } back_stat_t;

  function automatic logic is_arabic_block(input cp_t cp);
    return (cp >= ARB_LO  && cp <= ARB_HI)  || (cp >= SUP_LO && cp <= SUP_HI) ||
           (cp >= EXTB_LO && cp <= EXTB_HI) || (cp >= PFA_LO && cp <= PFA_HI) ||
           (cp >= PFB_LO  && cp <= PFB_HI);
  endfunction

  function automatic logic is_arabic_digit(input cp_t cp);
    return (cp >= DIG_LO && cp <= DIG_HI) || (cp >= SEP_LO && cp <= SEP_HI) ||
           (cp >= EDIG_LO && cp <= EDIG_HI);
  endfunction

endpackage

// ===== src/arsrc_front.sv =====
// Front end: accepts text bytes and decodes lenient UTF-8 into code points.
// Depends on arsrc_pkg.
module arsrc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_text_byte,
  input  logic                 in_run_end,
  input  logic                 q_full,
  output logic                 push,
  output arsrc_pkg::cp_item_t  push_item,
  output logic                 seq_open
);

  logic [2:0] seq_len_r, seq_len_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] pend0_r, pend0_nxt;
  logic [7:0] pend1_r, pend1_nxt;
  logic [7:0] lead_r, lead_nxt;
  logic       fire;
  logic       done;
  logic [2:0] new_len;
  arsrc_pkg::cp_t cp;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    if (b[7:5] == 3'b110) return arsrc_pkg::SEQ_LEN2;
    if (b[7:4] == 4'b1110) return arsrc_pkg::SEQ_LEN3;
    if (b[7:3] == 5'b11110) return arsrc_pkg::SEQ_LEN4;
    return arsrc_pkg::SEQ_NONE;
  endfunction

  assign fire     = in_valid & ~q_full;
  assign in_stall = q_full;
  assign new_len  = lead_len(in_text_byte);
  assign seq_open = (seq_len_r != arsrc_pkg::SEQ_NONE);

  always_comb begin
    seq_len_nxt = seq_len_r;
    cnt_nxt     = cnt_r;
    pend0_nxt   = pend0_r;
    pend1_nxt   = pend1_r;
    lead_nxt    = lead_r;
    cp          = '0;
    done        = 1'b0;
    if (seq_open) begin
      unique case (seq_len_r)
        arsrc_pkg::SEQ_LEN2: done = 1'b1;
        arsrc_pkg::SEQ_LEN3: done = (cnt_r == 2'd1);
        arsrc_pkg::SEQ_LEN4: done = (cnt_r == 2'd2);
        default:             done = 1'b1;
      endcase
      if (done) begin
        unique case (seq_len_r)
          arsrc_pkg::SEQ_LEN2: cp = {10'b0, lead_r[4:0], in_text_byte[5:0]};
          arsrc_pkg::SEQ_LEN3: cp = {5'b0, lead_r[3:0], pend0_r[5:0], in_text_byte[5:0]};
          arsrc_pkg::SEQ_LEN4:
            cp = {lead_r[2:0], pend0_r[5:0], pend1_r[5:0], in_text_byte[5:0]};
          default:             cp = '0;
        endcase
        seq_len_nxt = arsrc_pkg::SEQ_NONE;
        cnt_nxt     = 2'd0;
      end else if (in_run_end) begin
        // Truncated run: lead counts as zero, rescan followers; only a two-byte
        // lead in the first follower slot can still decode.
        if (seq_len_r == arsrc_pkg::SEQ_LEN4 && cnt_r == 2'd1 && pend0_r[7:5] == 3'b110) begin
          cp = {10'b0, pend0_r[4:0], in_text_byte[5:0]};
        end
        seq_len_nxt = arsrc_pkg::SEQ_NONE;
        cnt_nxt     = 2'd0;
      end else begin
        if (cnt_r == 2'd0) begin
          pend0_nxt = in_text_byte;
        end else begin
          pend1_nxt = in_text_byte;
        end
        cnt_nxt = cnt_r + 2'd1;
      end
    end else if (new_len != arsrc_pkg::SEQ_NONE && !in_run_end) begin
      lead_nxt    = in_text_byte;
      seq_len_nxt = new_len;
      cnt_nxt     = 2'd0;
    end
  end

  assign push           = fire;
  assign push_item.cp   = cp;
  assign push_item.last = in_run_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r <= arsrc_pkg::SEQ_NONE;
      cnt_r     <= 2'd0;
    end else if (fire) begin
      seq_len_r <= seq_len_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pend0_r <= pend0_nxt;
      pend1_r <= pend1_nxt;
      lead_r  <= lead_nxt;
    end
  end

endmodule

// ===== src/arsrc_queue.sv =====
// Short register queue of decoded entries between front and back ends.
// Depends on arsrc_pkg.
module arsrc_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  arsrc_pkg::cp_item_t  push_item,
  input  logic                 pop,
  output arsrc_pkg::cp_item_t  head_item,
  output logic                 empty,
  output logic                 full,
  output arsrc_pkg::q_cnt_t    count
);

  arsrc_pkg::cp_item_t slots [arsrc_pkg::Q_DEPTH];
  arsrc_pkg::q_ptr_t   wr_ptr_r, rd_ptr_r;
  arsrc_pkg::q_cnt_t   cnt_r;

  assign empty     = (cnt_r == '0);
  assign full      = (cnt_r == arsrc_pkg::Q_CNT_FULL);
  assign count     = cnt_r;
  assign head_item = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + arsrc_pkg::q_ptr_t'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + arsrc_pkg::q_ptr_t'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + arsrc_pkg::q_cnt_t'(1);
        2'b01:   cnt_r <= cnt_r - arsrc_pkg::q_cnt_t'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== src/arsrc_back.sv =====
// Back end: classifies decoded code points, accumulates run flags and holds
// the result register. Depends on arsrc_pkg.
module arsrc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  arsrc_pkg::cp_item_t   head_item,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_has_arabic_script,
  output logic                  out_has_arabic_letter,
  output arsrc_pkg::back_stat_t stat
);

  logic out_valid_r;
  logic script_r, letter_r;
  logic script_out_r, letter_out_r;
  logic out_free;
  logic is_ar, is_letter;
  logic script_nxt, letter_nxt;
  logic pop_last;

  assign out_free   = ~out_valid_r | ~out_stall;
  // Non-final entries drain freely; a final one waits for the result register.
  assign pop        = ~q_empty & (~head_item.last | out_free);
  assign pop_last   = pop & head_item.last;
  assign is_ar      = arsrc_pkg::is_arabic_block(head_item.cp);
  assign is_letter  = is_ar & ~arsrc_pkg::is_arabic_digit(head_item.cp);
  assign script_nxt = script_r | is_ar;
  assign letter_nxt = letter_r | is_letter;

  assign stat.pop      = pop;
  assign stat.pop_last = pop_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      script_r    <= 1'b0;
      letter_r    <= 1'b0;
    end else begin
      if (pop_last) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (pop) begin
        // clear the run flags once the final entry hands them over
        script_r <= script_nxt & ~head_item.last;
        letter_r <= letter_nxt & ~head_item.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_last) begin
      script_out_r <= script_nxt;
      letter_out_r <= letter_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_has_arabic_script = script_out_r;
  assign out_has_arabic_letter = letter_out_r;

endmodule

// ===== src/arabic_script_run_classifier.sv =====
// Arabic script run classifier: lenient UTF-8 decode of a byte run, one byte per
// transaction, one result transaction per run at the run-end byte.
// Throughput: one byte per cycle while the queue is not full, else in_stall is high;
// decode is combinational. The run-end entry passes through the queue into the result
// register; a stalled result register backs up through a 4-entry queue.
// Reset (rst_n low, synchronous) clears decode state, queue, run flags and out_valid.
`include "arabic_script_run_classifier_defines.svh"

module arabic_script_run_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_run_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_has_arabic_script,
  output logic       out_has_arabic_letter
);

  logic                  push, pop;
  logic                  q_empty, q_full;
  logic                  front_seq_open;
  arsrc_pkg::cp_item_t   push_item, head_item;
  arsrc_pkg::q_cnt_t     q_count;
  arsrc_pkg::back_stat_t back_stat;

  arsrc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .in_run_end   (in_run_end),
    .q_full       (q_full),
    .push         (push),
    .push_item    (push_item),
    .seq_open     (front_seq_open)
  );

  arsrc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .empty     (q_empty),
    .full      (q_full),
    .count     (q_count)
  );

  arsrc_back u_back (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .q_empty               (q_empty),
    .head_item             (head_item),
    .pop                   (pop),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_has_arabic_script (out_has_arabic_script),
    .out_has_arabic_letter (out_has_arabic_letter),
    .stat                  (back_stat)
  );

  `ARSRC_ASSERT_NEXT(a_run_end_closes_seq, clk, rst_n, in_valid && !in_stall && in_run_end, !front_seq_open, "sequence still open after run end")
  `ARSRC_ASSERT(a_queue_bound, clk, rst_n, q_count <= arsrc_pkg::Q_CNT_FULL, "queue count overflow")
  `ARSRC_ASSERT(a_out_from_last, clk, rst_n, $rose(out_valid) |-> $past(back_stat.pop_last), "result without final entry")
  `ARSRC_ASSERT(a_no_pop_empty, clk, rst_n, back_stat.pop |-> (q_count != '0), "pop from empty queue")

endmodule
